/* hw/rtl/adq_pkg.sv */
// ----------------------------------------------------------------------------
// adq_pkg
// Shared types and constants for the array double-ended queue.
// ----------------------------------------------------------------------------
package adq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [2:0] {
    CMD_PUSH_REAR  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4
  } adq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_EMPTY   = 2'd2
  } adq_status_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0
  } adq_reg_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
  } adq_in_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
  } adq_out_t;

  typedef struct packed {
    logic load;
    logic exec;
  } adq_cmd_bus_t;

endpackage

/* hw/rtl/array_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// array_double_ended_queue
// Double-ended queue of signed 32-bit words in a fixed, non-circular array.
// ----------------------------------------------------------------------------
// Each command is taken when start is high and busy is low; the next cycle
// accesses the slot memory (whose read data is registered), and the cycle
// after that presents the result for one cycle with out_valid high. busy
// stays high from the acceptance until that result cycle ends, so no new
// command is taken before the result of the last one. The result is not
// held: the receiver must take it in the cycle out_valid is high. Write
// the capacity register only while busy is low.
module array_double_ended_queue
  import adq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  adq_in_t     in_item,
  output logic        out_valid,
  output adq_out_t    out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  adq_cmd_bus_t     dp_cmd;
  logic [CAP_W-1:0] capacity_r;
  adq_reg_t         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = adq_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (psel && penable && pwrite && reg_sel == REG_CAPACITY) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_CAPACITY: prdata = {{(32-CAP_W){1'b0}}, capacity_r};
      default:      prdata = '0;
    endcase
  end

  adq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .dp_cmd    (dp_cmd)
  );

  adq_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .dp_cmd   (dp_cmd),
    .in_item  (in_item),
    .capacity (capacity_r),
    .out_item (out_item)
  );

endmodule

/* hw/rtl/adq_ctrl.sv */
// ----------------------------------------------------------------------------
// adq_ctrl
// Command sequencer: accept, slot access, result strobe.
// ----------------------------------------------------------------------------
module adq_ctrl
  import adq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  output logic         out_valid,
  output adq_cmd_bus_t dp_cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt     = S_RESP;
        out_valid_nxt = 1'b1;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign dp_cmd.load = start && (state_r == S_IDLE);
  assign dp_cmd.exec = (state_r == S_EXEC);

endmodule

/* hw/rtl/adq_dpath.sv */
// ----------------------------------------------------------------------------
// adq_dpath
// Queue datapath: slot memory, front and rear indices, result register.
// ----------------------------------------------------------------------------
module adq_dpath
  import adq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  adq_cmd_bus_t     dp_cmd,
  input  adq_in_t          in_item,
  input  logic [CAP_W-1:0] capacity,
  output adq_out_t         out_item
);

  logic [31:0]      mem [DEPTH];
  logic [2:0]       cmd_r;
  logic [31:0]      value_r;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] rear_r, rear_nxt;
  logic             empty_r, empty_nxt;
  logic [31:0]      rd_data_r;
  logic             rd_sel_r, rd_sel_nxt;
  adq_status_t      status_r, status_nxt;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [CAP_W-1:0] eff_cap;
  logic [IDX_W:0]   rear_inc;

  always_comb begin
    eff_cap = capacity;
    if (capacity == '0) eff_cap = CAP_W'(1);
    if ({{(32-CAP_W){1'b0}}, capacity} > 32'(DEPTH)) eff_cap = CAP_W'(DEPTH);
  end

  assign rear_inc = {1'b0, rear_r} + (IDX_W+1)'(1);

  always_comb begin
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    empty_nxt  = empty_r;
    status_nxt = ST_OK;
    rd_sel_nxt = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = rear_r;
    rd_addr    = front_r;
    case (cmd_r)
      CMD_PUSH_REAR: begin
        if (empty_r) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          front_nxt = '0;
          rear_nxt  = '0;
          empty_nxt = 1'b0;
        end else if (32'(rear_inc) >= 32'(eff_cap)) begin
          status_nxt = ST_NO_ROOM;
        end else begin
          wr_en    = 1'b1;
          wr_addr  = rear_inc[IDX_W-1:0];
          rear_nxt = rear_inc[IDX_W-1:0];
        end
      end
      CMD_PUSH_FRONT: begin
        if (empty_r) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          front_nxt = '0;
          rear_nxt  = '0;
          empty_nxt = 1'b0;
        end else if (front_r == '0) begin
          status_nxt = ST_NO_ROOM;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = front_r - IDX_W'(1);
          front_nxt = front_r - IDX_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_sel_nxt = 1'b1;
          rd_addr    = front_r;
          if (front_r >= rear_r) begin
            front_nxt = '0;
            rear_nxt  = '0;
            empty_nxt = 1'b1;
          end else begin
            front_nxt = front_r + IDX_W'(1);
          end
        end
      end
      CMD_POP_REAR: begin
        if (empty_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_sel_nxt = 1'b1;
          rd_addr    = rear_r;
          if (rear_r <= front_r) begin
            front_nxt = '0;
            rear_nxt  = '0;
            empty_nxt = 1'b1;
          end else begin
            rear_nxt = rear_r - IDX_W'(1);
          end
        end
      end
      CMD_PEEK_FRONT: begin
        if (empty_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_sel_nxt = 1'b1;
          rd_addr    = front_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec && wr_en) mem[wr_addr] <= value_r;
    if (dp_cmd.exec) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r   <= in_item.command;
      value_r <= in_item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      rear_r   <= '0;
      empty_r  <= 1'b1;
      rd_sel_r <= 1'b0;
      status_r <= ST_OK;
    end else if (dp_cmd.exec) begin
      front_r  <= front_nxt;
      rear_r   <= rear_nxt;
      empty_r  <= empty_nxt;
      rd_sel_r <= rd_sel_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_item.data   = rd_sel_r ? rd_data_r : 32'sd0;
  assign out_item.status = status_r;

endmodule

/* bench/array_double_ended_queue_test.sv */
// ----------------------------------------------------------------------------
// array_double_ended_queue_test
// Self-checking bench for the array deque. Commands go in through start/busy
// and capacity is set over the APB port while the block is idle. A scoreboard
// keeps its own copy of the array and indices, predicts one result per
// accepted command and compares each strobed result in order. Random bursts
// mix fills and drains so the queue runs against both ends at many capacities.
// ----------------------------------------------------------------------------
module array_double_ended_queue_test;
  import adq_pkg::*;

  localparam int CMD_CODE_MAX = 7;
  localparam int STALL_LIMIT = 400;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS = 80;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  class deque_scoreboard;
    logic [31:0] slots [DEPTH];
    int unsigned front_idx;
    int unsigned rear_idx;
    bit queue_empty;
    logic [CAP_W-1:0] capacity;
    adq_out_t expected_q[$];
    int errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      front_idx = 0;
      rear_idx = 0;
      queue_empty = 1'b1;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int unsigned usable_slots();
      int unsigned c;
      c = capacity;
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
    endfunction

    function void make_empty();
      front_idx = 0;
      rear_idx = 0;
      queue_empty = 1'b1;
    endfunction

    function void place_first(logic [31:0] v);
      slots[0] = v;
      front_idx = 0;
      rear_idx = 0;
      queue_empty = 1'b0;
    endfunction

    function void note_command(adq_in_t c);
      adq_out_t exp;
      adq_status_t st;
      logic [31:0] word;
      st = ST_OK;
      word = '0;
      case (c.command)
        CMD_PUSH_REAR: begin
          if (queue_empty) place_first(c.value);
          else if (rear_idx + 1 >= usable_slots()) st = ST_NO_ROOM;
          else begin
            rear_idx++;
            slots[rear_idx] = c.value;
          end
        end
        CMD_PUSH_FRONT: begin
          if (queue_empty) place_first(c.value);
          else if (front_idx == 0) st = ST_NO_ROOM;
          else begin
            front_idx--;
            slots[front_idx] = c.value;
          end
        end
        CMD_POP_FRONT: begin
          if (queue_empty) st = ST_EMPTY;
          else begin
            word = slots[front_idx];
            if (front_idx >= rear_idx) make_empty();
            else front_idx++;
          end
        end
        CMD_POP_REAR: begin
          if (queue_empty) st = ST_EMPTY;
          else begin
            word = slots[rear_idx];
            if (rear_idx <= front_idx) make_empty();
            else rear_idx--;
          end
        end
        CMD_PEEK_FRONT: begin
          if (queue_empty) st = ST_EMPTY;
          else word = slots[front_idx];
        end
        default: begin
        end
      endcase
      exp.data = word;
      exp.status = st;
      expected_q.push_back(exp);
    endfunction

    function void check_result(adq_out_t got);
      adq_out_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual data %0d status %0d",
                 $time, $signed(got.data), got.status);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.data !== exp.data) begin
        $display("%0t data mismatch: expected %0d actual %0d",
                 $time, $signed(exp.data), $signed(got.data));
        errors++;
      end
      if (got.status !== exp.status) begin
        $display("%0t status mismatch: expected %0d actual %0d",
                 $time, exp.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  adq_in_t in_item = '0;
  logic out_valid;
  adq_out_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  deque_scoreboard sb = new();
  int stall_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  array_double_ended_queue u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_command(mix_t m);
    int roll;
    int t_pr, t_pf, t_popf, t_popr, t_peek;
    roll = $urandom_range(0, 99);
    case (m)
      MIX_FILL: begin
        t_pr = 60; t_pf = 70; t_popf = 80; t_popr = 88; t_peek = 96;
      end
      MIX_DRAIN: begin
        t_pr = 15; t_pf = 25; t_popf = 55; t_popr = 85; t_peek = 95;
      end
      default: begin
        t_pr = 35; t_pf = 55; t_popf = 70; t_popr = 85; t_peek = 95;
      end
    endcase
    if (roll < t_pr) return CMD_PUSH_REAR;
    if (roll < t_pf) return CMD_PUSH_FRONT;
    if (roll < t_popf) return CMD_POP_FRONT;
    if (roll < t_popr) return CMD_POP_REAR;
    if (roll < t_peek) return CMD_PEEK_FRONT;
    return 3'($urandom_range(int'(CMD_PEEK_FRONT) + 1, CMD_CODE_MAX));
  endfunction

  // start stays high after a transfer so back-to-back commands need no toggle
  task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] val);
    adq_in_t c;
    c.command = cmd;
    c.value = val;
    start <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(c);
  endtask

  task automatic idle_gap(input int n);
    start <= 1'b0;
    in_item <= {3'($urandom()), 32'($urandom())};
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(REG_CAPACITY) << 2;
    pwdata <= 32'(c);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_capacity(c);
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [10];
    mix_t mix;
    bit quiet;

    phase_caps = '{7'd127, 7'd64, 7'd0, 7'd3, 7'd63, 7'd2, 7'd65, 7'd0, 7'd1, 7'd64};
    phase_caps[7] = 7'($urandom_range(0, 127));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue, both ends, extremes of the word
    send_cmd(CMD_PEEK_FRONT, rand_word());
    send_cmd(CMD_POP_FRONT, rand_word());
    send_cmd(CMD_POP_REAR, rand_word());
    send_cmd(CMD_PUSH_REAR, 32'h7fff_ffff);
    send_cmd(CMD_PUSH_REAR, 32'h8000_0000);
    send_cmd(CMD_PUSH_REAR, 32'hffff_ffff);
    send_cmd(CMD_POP_FRONT, rand_word());
    send_cmd(CMD_PUSH_FRONT, 32'h0000_0000);
    send_cmd(CMD_PUSH_FRONT, 32'h0000_0005);
    send_cmd(CMD_PEEK_FRONT, rand_word());
    send_cmd(CMD_POP_REAR, rand_word());
    send_cmd(CMD_POP_REAR, rand_word());
    send_cmd(CMD_POP_FRONT, rand_word());
    send_cmd(CMD_POP_REAR, rand_word());
    send_cmd(CMD_PUSH_FRONT, 32'h0000_007b);
    send_cmd(3'(int'(CMD_PEEK_FRONT) + 1), rand_word());
    send_cmd(3'(CMD_CODE_MAX), rand_word());
    send_cmd(CMD_POP_REAR, rand_word());

    // small capacity, then lowered below the contents
    wait_results();
    write_capacity(7'd2);
    send_cmd(CMD_PUSH_REAR, rand_word());
    send_cmd(CMD_PUSH_REAR, rand_word());
    send_cmd(CMD_PUSH_REAR, rand_word());
    wait_results();
    write_capacity(7'd1);
    send_cmd(CMD_PUSH_REAR, rand_word());
    send_cmd(CMD_PEEK_FRONT, rand_word());
    send_cmd(CMD_POP_REAR, rand_word());
    send_cmd(CMD_POP_REAR, rand_word());
    wait_results();
    write_capacity(7'd0);
    send_cmd(CMD_PUSH_REAR, rand_word());
    send_cmd(CMD_PUSH_REAR, rand_word());

    mix = MIX_FILL;
    foreach (phase_caps[p]) begin
      quiet = (p == $size(phase_caps) - 1);
      wait_results();
      write_capacity(phase_caps[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 24) == 0) mix = mix_t'($urandom_range(0, 2));
        if (!quiet && $urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 16));
        else if (!quiet && $urandom_range(0, 39) == 0) wait_results();
        send_cmd(pick_command(mix), rand_word());
      end
    end

    wait_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
